// ===== rtl/core/mas_pkg.sv =====
// Shared types and constants for the moving-average signal block.
package mas_pkg;

   // Window length register width and reset value.
   localparam int WIN_BITS = 7;
   localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(3);

   // Parameter defaults.
   localparam int MAX_WINDOW_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 32;

   // Trade signal codes carried on rsp_tuser.
   typedef enum logic [1:0] {
      SIG_HOLD = 2'd0,
      SIG_BUY  = 2'd1,
      SIG_SELL = 2'd2
   } signal_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/moving_average_signal.sv =====
// Top level of the moving-average signal block: sample ring, running sum and serial divider.
//
// Takes one unsigned fixed-point price per input transfer and returns one result per
// item: the mean of the last window_length samples of the current series (fewer while
// the series is still filling), truncated toward zero, plus a buy/sell/hold code that
// compares price * count against the running sum exactly. The samples live in a
// single-port-write ring memory with a registered read; the sample leaving the window
// is read at transfer time, and the new sample is written back in the cycle after.
// An item passes through the accept cycle, an update state, the restoring divider at
// one cycle per quotient bit (SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW + 1) bits), and a
// finish state that hands the result to the output register once it is free; no new
// item is taken before then. The output register lets the next item be accepted while
// a finished result still waits for rsp_tready. Setting series_start on a transfer
// clears sum and count before that sample; a write on the csr port, taken only while
// idle, sets the window length and also starts a new series. Window length zero acts
// as one, and values above MAX_WINDOW act as MAX_WINDOW.
module moving_average_signal #(
   parameter int MAX_WINDOW  = mas_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,  // [SAMPLE_BITS-1:0] price
   input  logic [0:0]                             req_tuser,  // [0] series_start
   // result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,  // [SAMPLE_BITS-1:0] average
   output logic [1:0]                             rsp_tuser,  // [1:0] signal
   // configuration
   input  logic                                   csr_we,
   input  logic [mas_pkg::WIN_BITS-1:0]           csr_wdata   // window_length
);

   localparam int WB      = mas_pkg::WIN_BITS;
   localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int XW      = SLOT_W + 1;
   localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
   localparam int PROD_W  = SAMPLE_BITS + WB;
   localparam int CMP_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
   localparam int STEP_W  = $clog2(SUM_W);
   localparam int WIN_CAP = (MAX_WINDOW < (2**WB - 1)) ? MAX_WINDOW : (2**WB - 1);

   localparam logic [WB-1:0]     WIN_CAP_V = WB'(WIN_CAP);
   localparam logic [XW-1:0]     MAX_X     = XW'(MAX_WINDOW);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WINDOW - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   // control state
   mas_pkg::state_type state_ff, state_in;
   logic [WB-1:0]          window_ff, window_in;
   logic [WB-1:0]          count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic [SAMPLE_BITS-1:0] price_ff, price_in;
   logic                   start_ff, start_in;
   logic                   need_sub_ff, need_sub_in;
   logic [WB-1:0]          div_ff, div_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SUM_W-1:0]       quo_ff, quo_in;
   logic [WB-1:0]          rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [SAMPLE_BITS-1:0] rsp_avg_ff, rsp_avg_in;
   mas_pkg::signal_type    rsp_sig_ff, rsp_sig_in;

   // sample ring
   logic [SAMPLE_BITS-1:0] ring [0:MAX_WINDOW-1];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   rd_en;
   logic [SLOT_W-1:0]      rd_addr;
   logic                   wr_en;

   // combinational helpers
   logic [WB-1:0]          win_eff;
   logic [WB-1:0]          cnt_base;
   logic [SUM_W-1:0]       sum_base;
   logic [SUM_W-1:0]       new_sum;
   logic [WB-1:0]          new_cnt;
   logic [XW-1:0]          slot_x, win_x, old_x;
   logic [WB:0]            trial;
   logic [CMP_W-1:0]       prod_cmp, sum_cmp;

   // Effective window: zero acts as one, clamp at ring depth.
   always_comb begin
      win_eff = window_ff;
      if (window_ff == '0) begin
         win_eff = WB'(1);
      end else if (window_ff > WIN_CAP_V) begin
         win_eff = WIN_CAP_V;
      end
   end

   // Slot of the sample leaving the window: slot - w, modulo the ring depth.
   assign slot_x = {1'b0, slot_ff};
   assign win_x  = XW'(win_eff);
   assign old_x  = (slot_x >= win_x) ? (slot_x - win_x) : (slot_x + MAX_X - win_x);

   // Restoring division, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[SUM_W-1]};

   assign prod_cmp = CMP_W'(prod_ff);
   assign sum_cmp  = CMP_W'(sum_ff);

   assign req_tready = (state_ff == mas_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_avg_ff);
   assign rsp_tuser  = rsp_sig_ff;

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      price_in     = price_ff;
      start_in     = start_ff;
      need_sub_in  = need_sub_ff;
      div_in       = div_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_sig_in   = rsp_sig_ff;
      rd_en        = 1'b0;
      rd_addr      = old_x[SLOT_W-1:0];
      wr_en        = 1'b0;
      cnt_base     = start_ff ? '0 : count_ff;
      sum_base     = start_ff ? '0 : sum_ff;
      new_sum      = sum_base - (need_sub_ff ? SUM_W'(rd_data_ff) : '0) + SUM_W'(price_ff);
      new_cnt      = need_sub_ff ? cnt_base : cnt_base + WB'(1);

      case (state_ff)
         mas_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               // fetch the outgoing sample now; it is back for the update cycle
               price_in    = req_tdata[SAMPLE_BITS-1:0];
               start_in    = req_tuser[0];
               need_sub_in = (req_tuser[0] ? '0 : count_ff) >= win_eff;
               rd_en       = 1'b1;
               state_in    = mas_pkg::ST_UPDATE;
            end
            // window change starts a new series
            if (csr_we) begin
               window_in = csr_wdata;
               count_in  = '0;
               sum_in    = '0;
            end
         end
         mas_pkg::ST_UPDATE: begin
            sum_in   = new_sum;
            count_in = new_cnt;
            div_in   = new_cnt;
            prod_in  = PROD_W'(price_ff) * PROD_W'(new_cnt);
            quo_in   = new_sum;
            rem_in   = '0;
            step_in  = '0;
            wr_en    = 1'b1;
            slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
            state_in = mas_pkg::ST_DIVIDE;
         end
         mas_pkg::ST_DIVIDE: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = WB'(trial - {1'b0, div_ff});
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[WB-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = mas_pkg::ST_FINISH;
            end
         end
         mas_pkg::ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_avg_in   = quo_ff[SAMPLE_BITS-1:0];
               rsp_valid_in = 1'b1;
               if (prod_cmp > sum_cmp) begin
                  rsp_sig_in = mas_pkg::SIG_BUY;
               end else if (prod_cmp < sum_cmp) begin
                  rsp_sig_in = mas_pkg::SIG_SELL;
               end else begin
                  rsp_sig_in = mas_pkg::SIG_HOLD;
               end
               state_in = mas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mas_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mas_pkg::ST_IDLE;
         window_ff    <= mas_pkg::WINDOW_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff    <= price_in;
      start_ff    <= start_in;
      need_sub_ff <= need_sub_in;
      div_ff      <= div_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_sig_ff  <= rsp_sig_in;
   end

   // Ring memory: registered read; the write comes in the cycle after the read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring[rd_addr];
      end
      if (wr_en) begin
         ring[slot_ff] <= price_ff;
      end
   end

endmodule

// ===== rtl/core/mas_checker.sv =====
// Port-level checker for the moving-average signal block, with its bind.
module mas_checker #(
   parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser
);

   // one item at a time: busy right after an input transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an input transfer");

   // a result only appears out of a busy cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a busy cycle");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

   // reset empties the output register and frees the input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind moving_average_signal mas_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the moving-average signal block.
module testbench;

   localparam int RING_DEPTH = mas_pkg::MAX_WINDOW_DEF;
   localparam int PRICE_BITS = mas_pkg::SAMPLE_BITS_DEF;
   localparam int WIN_W      = mas_pkg::WIN_BITS;
   localparam int DATA_BITS  = ((PRICE_BITS + 7) / 8) * 8;
   localparam int HOLD_OFF   = 400;      // long receiver stall, in cycles
   localparam int SETTLE     = 60;       // quiet cycles after the last result
   localparam int RANDOM_TICKS = 1400;

   // One input transfer: price plus the series-start flag.
   typedef struct packed {
      logic [PRICE_BITS-1:0] price;
      logic                  series_start;
   } tick_type;

   // One result transfer: windowed mean plus trade code.
   typedef struct packed {
      logic [PRICE_BITS-1:0] average;
      mas_pkg::signal_type   trade_sig;
   } outcome_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;   // [31:0] price
   logic [0:0]           req_tuser  = '0;   // [0] series_start
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;         // [31:0] average
   logic [1:0]           rsp_tuser;         // [1:0] signal
   logic                 csr_we     = 1'b0;
   logic [WIN_W-1:0]     csr_wdata  = '0;

   moving_average_signal u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Ticks waiting to be sent, and results owed by the block in order.
   tick_type    pending_ticks[$];
   outcome_type expected_means[$];
   int          error_count = 0;

   // Receiver long-stall requests: the stimulus bumps the counter, the
   // receiver notices the change and counts the stall itself.
   int hold_requests = 0;
   int hold_seen     = 0;

   // Our own copy of the window state.
   logic [PRICE_BITS-1:0] ring_copy [RING_DEPTH];
   int unsigned           next_slot  = 0;
   int unsigned           fill_level = 0;
   logic [63:0]           window_sum = '0;
   logic [WIN_W-1:0]      window_reg = mas_pkg::WINDOW_RESET;
   logic [PRICE_BITS-1:0] last_price = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Take one accepted tick into the window and queue the result it owes.
   function automatic void advance_window(tick_type t);
      int unsigned span;
      int unsigned oldest;
      logic [63:0] scaled;
      outcome_type o;
      // zero acts as one, anything past the ring depth acts as the full ring
      span = (window_reg == 0) ? 1 : ((window_reg > RING_DEPTH) ? RING_DEPTH : window_reg);
      if (t.series_start) begin
         window_sum = '0;
         fill_level = 0;
      end
      // full window: oldest sample drops out before the new one goes in
      if (fill_level >= span) begin
         oldest = (next_slot + RING_DEPTH - span) % RING_DEPTH;
         window_sum -= ring_copy[oldest];
      end
      window_sum += t.price;
      ring_copy[next_slot] = t.price;
      next_slot = (next_slot + 1) % RING_DEPTH;
      if (fill_level < span)
         fill_level++;
      o.average = PRICE_BITS'(window_sum / fill_level);
      // exact compare, unaffected by truncation of the mean
      scaled = 64'(t.price) * fill_level;
      if (scaled > window_sum)
         o.trade_sig = mas_pkg::SIG_BUY;
      else if (scaled < window_sum)
         o.trade_sig = mas_pkg::SIG_SELL;
      else
         o.trade_sig = mas_pkg::SIG_HOLD;
      expected_means = {expected_means, o};
   endfunction

   // Sender: one tick per transfer, random gap after each.
   int send_gap  = 0;
   bit send_calm = 1'b0;
   always @(posedge clock) begin
      tick_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            t.price        = req_tdata[PRICE_BITS-1:0];
            t.series_start = req_tuser[0];
            advance_window(t);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               t = pending_ticks.pop_front();
               req_tdata  <= DATA_BITS'(t.price);
               req_tuser  <= t.series_start;
               req_tvalid <= 1'b1;
               // occasional stretches with no gaps at all
               if ($urandom_range(0, 39) == 0)
                  send_calm = !send_calm;
               send_gap = send_calm ? 0 : $urandom_range(0, 4);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result against the oldest owed one.
   int recv_wait = 0;
   bit recv_calm = 1'b0;
   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               $error("result with nothing owed: average %h signal %0d",
                      rsp_tdata[PRICE_BITS-1:0], rsp_tuser);
               error_count++;
            end else begin
               o = expected_means.pop_front();
               if (rsp_tdata[PRICE_BITS-1:0] !== o.average) begin
                  $error("average: expected %h, got %h", o.average, rsp_tdata[PRICE_BITS-1:0]);
                  error_count++;
               end
               if (rsp_tuser !== o.trade_sig) begin
                  $error("signal: expected %0d, got %0d", o.trade_sig, rsp_tuser);
                  error_count++;
               end
            end
            if ($urandom_range(0, 39) == 0)
               recv_calm = !recv_calm;
            recv_wait = recv_calm ? 0 : $urandom_range(0, 4);
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            recv_wait = HOLD_OFF;
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_tick(logic [PRICE_BITS-1:0] price, logic series_start);
      tick_type t;
      t.price        = price;
      t.series_start = series_start;
      pending_ticks = {pending_ticks, t};
   endtask

   // Wait until every tick has gone out and every result has come back.
   task automatic drain();
      @(posedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || expected_means.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Window write; only called with the block idle. Also starts a new series.
   task automatic set_window(logic [WIN_W-1:0] w);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we    <= 1'b0;
      window_reg = w;
      window_sum = '0;
      fill_level = 0;
   endtask

   // Mix of extremes, fresh values, small steps and repeats (repeats make holds).
   function automatic logic [PRICE_BITS-1:0] pick_price();
      logic [PRICE_BITS-1:0] p;
      case ($urandom_range(0, 9))
         0:       p = '0;
         1:       p = '1;
         2, 3, 4: p = PRICE_BITS'($urandom);
         5, 6:    p = last_price + PRICE_BITS'($urandom_range(0, 255)) - PRICE_BITS'(128);
         default: p = last_price;
      endcase
      last_price = p;
      return p;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         push_tick(pick_price(), $urandom_range(0, 24) == 0);
      drain();
   endtask

   initial begin
      int total;
      int n;
      logic [WIN_W-1:0] w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset window of three: extremes, hold, buy, sell, restarts
      push_tick('0, 1'b1);
      push_tick('0, 1'b0);
      push_tick('1, 1'b0);
      push_tick('1, 1'b0);
      push_tick('1, 1'b0);             // full window of max prices: hold
      push_tick(32'd100, 1'b0);         // sell
      push_tick('1, 1'b0);             // buy
      push_tick(32'd5, 1'b1);           // restart mid-stream
      push_tick(32'd7, 1'b0);
      push_tick(32'd3, 1'b0);
      push_tick(32'h0001_0000, 1'b1);
      push_tick(32'h0001_8000, 1'b0);   // mean of the two is exact
      push_tick(32'h0000_0001, 1'b0);
      push_tick(32'hAAAA_5555, 1'b0);
      push_tick(32'h5555_AAAA, 1'b0);
      drain();

      // window zero acts as one: always hold
      set_window('0);
      push_tick(32'd9, 1'b0);
      push_tick('1, 1'b0);
      push_tick('0, 1'b1);
      drain();

      // all-ones write: clamps to the full ring, run the sum to its top
      set_window('1);
      for (int i = 0; i < 70; i++)
         push_tick('1, 1'b0);
      push_tick('0, 1'b0);
      drain();

      // full ring with a long receiver stall so the input backs up
      set_window(WIN_W'(RING_DEPTH));
      hold_requests++;
      random_phase(120);

      total = 0;
      while (total < RANDOM_TICKS - 120) begin
         case ($urandom_range(0, 6))
            0:       w = WIN_W'(1);
            1:       w = WIN_W'(2);
            2:       w = WIN_W'(RING_DEPTH);
            3:       w = WIN_W'($urandom_range(RING_DEPTH + 1, 127));
            4:       w = '0;
            default: w = WIN_W'($urandom_range(1, RING_DEPTH));
         endcase
         // sometimes keep the series going across the pause
         if ($urandom_range(0, 3) != 0)
            set_window(w);
         if ($urandom_range(0, 4) == 0)
            hold_requests++;
         n = $urandom_range(60, 160);
         random_phase(n);
         total += n;
      end

      drain();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // time limit covering every tick plus gaps, stalls and pauses, with wide margin
   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
